// ===== sv/skvt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Shared widths, operation and status codes, and the command/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

  localparam int CMD_W         = 2;
  localparam int KEY_W         = 32;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 7;
  localparam int CAP_W         = 7;
  localparam int DEPTH_DEFAULT = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Operation codes on the command field
  typedef enum logic [CMD_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MODIFY = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Scan index update
  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_TOP,
    IDX_DOWN,
    IDX_UP
  } idx_op_t;

  // Read address select
  typedef enum logic [1:0] {
    RD_TOP,
    RD_DOWN,
    RD_UP
  } rd_sel_t;

  // Write address select
  typedef enum logic [1:0] {
    WA_ZERO,
    WA_AT,
    WA_ABOVE,
    WA_BELOW
  } wa_sel_t;

  // Write data select
  typedef enum logic {
    WD_ITEM,
    WD_READ
  } wd_sel_t;

  // Entry count update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load_item;
    idx_op_t idx_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    cnt_op_t cnt_op;
    logic    load_result;
    status_t res_status;
  } skvt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic key_gt;
    logic key_eq;
    logic idx_zero;
    logic idx_last;
  } skvt_stat_t;

endpackage

`default_nettype wire

// ===== sv/skvt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data; no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/skvt_dp.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table datapath
// Entry store, entry count, capacity register, scan index, key compare and
// the result payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_dp #(
  parameter int DEPTH = skvt_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic        [skvt_pkg::CAP_W-1:0]     cfg_wr_data,
  input  wire logic signed [skvt_pkg::KEY_W-1:0]     in_key,
  input  wire logic        [skvt_pkg::VALUE_W-1:0]   in_value,
  input  wire skvt_pkg::skvt_cmd_t                   cmd,
  output skvt_pkg::skvt_stat_t                       stat,
  output logic [skvt_pkg::STATUS_W-1:0]              out_status,
  output logic [skvt_pkg::ENTRY_COUNT_W-1:0]         out_entry_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = skvt_pkg::KEY_W + skvt_pkg::VALUE_W;
  localparam int CMP_W = (CNT_W > skvt_pkg::CAP_W) ? CNT_W : skvt_pkg::CAP_W;

  logic        [skvt_pkg::CAP_W-1:0]         cap_r;
  logic        [CNT_W-1:0]                   count_r;
  logic        [CNT_W-1:0]                   count_nxt;
  logic signed [skvt_pkg::KEY_W-1:0]         key_r;
  logic        [skvt_pkg::VALUE_W-1:0]       value_r;
  logic        [IDX_W-1:0]                   idx_r;
  logic        [IDX_W-1:0]                   idx_nxt;
  logic        [skvt_pkg::STATUS_W-1:0]      out_status_r;
  logic        [skvt_pkg::ENTRY_COUNT_W-1:0] out_entry_count_r;

  logic        [IDX_W-1:0]                   idx_top;
  logic        [IDX_W-1:0]                   idx_up;
  logic        [IDX_W-1:0]                   idx_dn;
  logic        [IDX_W-1:0]                   rd_addr;
  logic        [IDX_W-1:0]                   wr_addr;
  logic        [ENT_W-1:0]                   wr_data;
  logic        [ENT_W-1:0]                   rd_data;
  logic signed [skvt_pkg::KEY_W-1:0]         rd_key;
  logic        [CMP_W-1:0]                   count_ext;

  // Neighbor addresses of the scan index
  assign idx_top   = IDX_W'(count_r - CNT_W'(1));
  assign idx_up    = idx_r + IDX_W'(1);
  assign idx_dn    = idx_r - IDX_W'(1);
  assign count_ext = CMP_W'(count_r);
  assign rd_key    = rd_data[ENT_W-1:skvt_pkg::VALUE_W];

  // Capacity register and entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= skvt_pkg::CAP_RESET;
      count_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
    end
  end

  // Payload: transaction key/value, scan index, result
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      key_r   <= in_key;
      value_r <= in_value;
    end
    idx_r <= idx_nxt;
    if (cmd.load_result) begin
      out_status_r      <= cmd.res_status;
      out_entry_count_r <= count_ext[skvt_pkg::ENTRY_COUNT_W-1:0];
    end
  end

  // Next count
  always_comb begin
    case (cmd.cnt_op)
      skvt_pkg::CNT_INC: count_nxt = count_r + CNT_W'(1);
      skvt_pkg::CNT_DEC: count_nxt = count_r - CNT_W'(1);
      default:           count_nxt = count_r;
    endcase
  end

  // Next scan index
  always_comb begin
    case (cmd.idx_op)
      skvt_pkg::IDX_TOP:  idx_nxt = idx_top;
      skvt_pkg::IDX_DOWN: idx_nxt = idx_dn;
      skvt_pkg::IDX_UP:   idx_nxt = idx_up;
      default:            idx_nxt = idx_r;
    endcase
  end

  // Read address
  always_comb begin
    case (cmd.rd_sel)
      skvt_pkg::RD_DOWN: rd_addr = idx_dn;
      skvt_pkg::RD_UP:   rd_addr = idx_up;
      default:           rd_addr = idx_top;
    endcase
  end

  // Write address and data
  always_comb begin
    case (cmd.wa_sel)
      skvt_pkg::WA_AT:    wr_addr = idx_r;
      skvt_pkg::WA_ABOVE: wr_addr = idx_up;
      skvt_pkg::WA_BELOW: wr_addr = idx_dn;
      default:            wr_addr = '0;
    endcase
    if (cmd.wd_sel == skvt_pkg::WD_READ) begin
      wr_data = rd_data;
    end else begin
      wr_data = {key_r, value_r};
    end
  end

  // Entry store: key in the upper half, value in the lower half
  skvt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Status to the controller
  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_ext >= CMP_W'(cap_r)) || (count_r == CNT_W'(DEPTH));
  assign stat.key_gt   = (rd_key > key_r);
  assign stat.key_eq   = (rd_key == key_r);
  assign stat.idx_zero = (idx_r == '0);
  assign stat.idx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_op == skvt_pkg::CNT_INC |-> !stat.full)
    else $error("entry added to a full table");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_op == skvt_pkg::CNT_DEC |-> !stat.empty)
    else $error("entry removed from an empty table");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> CNT_W'(wr_addr) <= count_r)
    else $error("store write beyond the occupied entries");
`endif

endmodule

`default_nettype wire

// ===== sv/skvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table controller
// Sequences one transaction at a time: dispatch, downward scan with shift for
// add, search down for remove/modify, upward shift for remove, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [skvt_pkg::CMD_W-1:0]        in_command,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  input  wire skvt_pkg::skvt_stat_t              stat,
  output skvt_pkg::skvt_cmd_t                    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_SCAN,
    S_ADD_LOW,
    S_FIND,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  skvt_pkg::op_t       op_r;
  skvt_pkg::op_t       op_nxt;
  skvt_pkg::status_t   st_r;
  skvt_pkg::status_t   st_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= skvt_pkg::OP_ADD;
      st_r        <= skvt_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    st_nxt          = st_r;
    out_valid_nxt   = out_valid_r && out_stall;
    cmd.load_item   = 1'b0;
    cmd.idx_op      = skvt_pkg::IDX_HOLD;
    cmd.rd_en       = 1'b0;
    cmd.rd_sel      = skvt_pkg::RD_TOP;
    cmd.wr_en       = 1'b0;
    cmd.wa_sel      = skvt_pkg::WA_ZERO;
    cmd.wd_sel      = skvt_pkg::WD_ITEM;
    cmd.cnt_op      = skvt_pkg::CNT_HOLD;
    cmd.load_result = 1'b0;
    cmd.res_status  = st_r;

    case (state_r)
      // Take a transaction
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          op_nxt        = skvt_pkg::op_t'(in_command);
          state_nxt     = S_DISPATCH;
        end
      end

      // Decide trivial cases, else start the scan at the top entry
      S_DISPATCH: begin
        case (op_r)
          skvt_pkg::OP_ADD: begin
            if (stat.full) begin
              st_nxt    = skvt_pkg::ST_FULL;
              state_nxt = S_RESP;
            end else if (stat.empty) begin
              cmd.wr_en  = 1'b1;
              cmd.wa_sel = skvt_pkg::WA_ZERO;
              cmd.cnt_op = skvt_pkg::CNT_INC;
              st_nxt     = skvt_pkg::ST_OK;
              state_nxt  = S_RESP;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = skvt_pkg::RD_TOP;
              cmd.idx_op = skvt_pkg::IDX_TOP;
              state_nxt  = S_ADD_SCAN;
            end
          end
          skvt_pkg::OP_REMOVE, skvt_pkg::OP_MODIFY: begin
            if (stat.empty) begin
              st_nxt    = skvt_pkg::ST_NOT_FOUND;
              state_nxt = S_RESP;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = skvt_pkg::RD_TOP;
              cmd.idx_op = skvt_pkg::IDX_TOP;
              state_nxt  = S_FIND;
            end
          end
          default: begin
            st_nxt    = skvt_pkg::ST_OK;
            state_nxt = S_RESP;
          end
        endcase
      end

      // Move greater entries up one place, insert above the first that is not
      S_ADD_SCAN: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = skvt_pkg::WA_ABOVE;
        if (stat.key_gt) begin
          cmd.wd_sel = skvt_pkg::WD_READ;
          if (stat.idx_zero) begin
            state_nxt = S_ADD_LOW;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = skvt_pkg::RD_DOWN;
            cmd.idx_op = skvt_pkg::IDX_DOWN;
          end
        end else begin
          cmd.wd_sel = skvt_pkg::WD_ITEM;
          cmd.cnt_op = skvt_pkg::CNT_INC;
          st_nxt     = skvt_pkg::ST_OK;
          state_nxt  = S_RESP;
        end
      end

      // New key is the smallest: place it at the bottom
      S_ADD_LOW: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = skvt_pkg::WA_ZERO;
        cmd.wd_sel = skvt_pkg::WD_ITEM;
        cmd.cnt_op = skvt_pkg::CNT_INC;
        st_nxt     = skvt_pkg::ST_OK;
        state_nxt  = S_RESP;
      end

      // Search down for the last entry not greater than the key
      S_FIND: begin
        if (stat.key_gt) begin
          if (stat.idx_zero) begin
            st_nxt    = skvt_pkg::ST_NOT_FOUND;
            state_nxt = S_RESP;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = skvt_pkg::RD_DOWN;
            cmd.idx_op = skvt_pkg::IDX_DOWN;
          end
        end else if (!stat.key_eq) begin
          st_nxt    = skvt_pkg::ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else if (op_r == skvt_pkg::OP_MODIFY) begin
          cmd.wr_en  = 1'b1;
          cmd.wa_sel = skvt_pkg::WA_AT;
          cmd.wd_sel = skvt_pkg::WD_ITEM;
          st_nxt     = skvt_pkg::ST_OK;
          state_nxt  = S_RESP;
        end else if (stat.idx_last) begin
          cmd.cnt_op = skvt_pkg::CNT_DEC;
          st_nxt     = skvt_pkg::ST_OK;
          state_nxt  = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = skvt_pkg::RD_UP;
          cmd.idx_op = skvt_pkg::IDX_UP;
          state_nxt  = S_SHIFT;
        end
      end

      // Close the gap: move each later entry down one place
      S_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = skvt_pkg::WA_BELOW;
        cmd.wd_sel = skvt_pkg::WD_READ;
        if (stat.idx_last) begin
          cmd.cnt_op = skvt_pkg::CNT_DEC;
          st_nxt     = skvt_pkg::ST_OK;
          state_nxt  = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = skvt_pkg::RD_UP;
          cmd.idx_op = skvt_pkg::IDX_UP;
        end
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_result = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> (!out_valid_r || !out_stall))
    else $error("result loaded over an untaken result");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside the response state");
`endif

endmodule

`default_nettype wire

// ===== sv/sorted_key_value_table_top.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table, top level
// Add scans down from the top with one store read per entry scanned,
//   shifting as it goes; remove and modify search downward, and remove
//   then moves each later entry down one place.
// Throughput: one transaction at a time, set by the single read port of the
//   entry store; the output register lets the next transaction in while a
//   result waits. Reset clears count and control, sets capacity to 64; the
//   store is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table_top #(
  parameter int DEPTH = skvt_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic        [skvt_pkg::CAP_W-1:0]     cfg_wr_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic        [skvt_pkg::CMD_W-1:0]     in_command,
  input  wire logic signed [skvt_pkg::KEY_W-1:0]     in_key,
  input  wire logic        [skvt_pkg::VALUE_W-1:0]   in_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [skvt_pkg::STATUS_W-1:0]              out_status,
  output logic [skvt_pkg::ENTRY_COUNT_W-1:0]         out_entry_count
);

  skvt_pkg::skvt_cmd_t  cmd;
  skvt_pkg::skvt_stat_t stat;

  // Sequencer
  skvt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Store, count and compare
  skvt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_key          (in_key),
    .in_value        (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table testbench
// Drives add, remove, modify and unused commands through the valid/stall
// input channel and checks each status and entry count against a shadow
// copy of the table kept here. Directed tests cover the empty table, extreme
// and duplicate keys and capacity corners. Phases of random traffic
// follow, with random gaps on both channels and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import skvt_pkg::*;

  localparam int TABLE_DEPTH   = DEPTH_DEFAULT;
  localparam int MAX_CYCLES    = 1_000_000;
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
  localparam int MAX_REPORTS   = 10;
  localparam int LONG_HOLD     = 400;

  // Command code outside the operation set; the table must ignore it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    status_t                    status;
    logic [ENTRY_COUNT_W-1:0]   entry_count;
  } table_reply_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]            cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [CMD_W-1:0]            in_command = '0;
  logic signed [KEY_W-1:0]     in_key = '0;
  logic [VALUE_W-1:0]          in_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [STATUS_W-1:0]         out_status;
  logic [ENTRY_COUNT_W-1:0]    out_entry_count;

  sorted_key_value_table_top #(
    .DEPTH(TABLE_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow table and bookkeeping
  logic signed [KEY_W-1:0] shadow_keys   [TABLE_DEPTH];
  logic [VALUE_W-1:0]      shadow_values [TABLE_DEPTH];
  int                      shadow_count = 0;
  int                      shadow_capacity = CAP_RESET;
  table_reply_t            expected_replies[$];

  bit idling_on = 1'b1;
  int long_hold_cycles = 0;
  int cycle_count = 0;
  int error_count = 0;
  int commands_sent = 0;
  int replies_checked = 0;
  int capacity_writes = 0;
  int peak_count = 0;
  int long_holds = 0;

  // First position holding a key greater than k, or the count if none
  function automatic int first_above(input logic signed [KEY_W-1:0] k);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] > k) return i;
    end
    return shadow_count;
  endfunction

  // Apply one command to the shadow table and return the reply it produces
  function automatic table_reply_t update_shadow_table(input logic [CMD_W-1:0] cmd,
                                                       input logic signed [KEY_W-1:0] k,
                                                       input logic [VALUE_W-1:0] v);
    table_reply_t reply;
    int pos;
    int limit;
    reply.status = ST_OK;
    limit = (shadow_capacity < TABLE_DEPTH) ? shadow_capacity : TABLE_DEPTH;
    case (cmd)
      OP_ADD: begin
        if (shadow_count >= limit) begin
          reply.status = ST_FULL;
        end else begin
          // insert after equal keys, shift the rest up
          pos = first_above(k);
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i]   = shadow_keys[i-1];
            shadow_values[i] = shadow_values[i-1];
          end
          shadow_keys[pos]   = k;
          shadow_values[pos] = v;
          shadow_count++;
        end
      end
      OP_REMOVE, OP_MODIFY: begin
        // the last entry with this key sits just below the first greater one
        pos = first_above(k);
        if (pos == 0 || shadow_keys[pos-1] != k) begin
          reply.status = ST_NOT_FOUND;
        end else if (cmd == OP_MODIFY) begin
          shadow_values[pos-1] = v;
        end else begin
          for (int i = pos - 1; i + 1 < shadow_count; i++) begin
            shadow_keys[i]   = shadow_keys[i+1];
            shadow_values[i] = shadow_values[i+1];
          end
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    reply.entry_count = shadow_count[ENTRY_COUNT_W-1:0];
    return reply;
  endfunction

  // Mostly small keys so duplicates and hits are common, some extremes
  function automatic logic signed [KEY_W-1:0] random_key();
    int roll;
    int offset;
    roll = $urandom_range(0, 9);
    offset = $urandom_range(0, 16);
    if (roll < 5) return offset - 8;
    if (roll == 5) begin
      case (offset % 4)
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return 0;
        default: return -1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic note_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Offer one transaction after a random gap and record its reply on accept
  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic signed [KEY_W-1:0] k,
                              input logic [VALUE_W-1:0] v);
    int gap;
    gap = idling_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command = cmd;
    in_key     = k;
    in_value   = v;
    in_valid   = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_replies.push_back(update_shadow_table(cmd, k, v));
    commands_sent++;
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  // Drop valid and hold off until every reply has come back
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // Write the capacity register while the table is idle
  task automatic write_capacity(input int cap);
    wait_for_drain();
    @(negedge clk);
    cfg_wr_data = cap[CAP_W-1:0];
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    shadow_capacity = cap;
    capacity_writes++;
  endtask

  // Random command; bias sets how often adds come (fill, churn, drain)
  task automatic send_random_command(input int bias);
    int roll;
    int add_pct;
    logic [CMD_W-1:0] cmd;
    logic signed [KEY_W-1:0] k;
    add_pct = (bias == 0) ? 65 : (bias == 1) ? 40 : 20;
    roll = $urandom_range(0, 99);
    if (roll < 3) cmd = CMD_UNUSED;
    else if (roll < 3 + add_pct) cmd = OP_ADD;
    else if (roll < 3 + add_pct + (97 - add_pct) / 2) cmd = OP_REMOVE;
    else cmd = OP_MODIFY;
    // remove and modify mostly target a live key
    if (cmd != OP_ADD && shadow_count > 0 && $urandom_range(0, 3) != 0)
      k = shadow_keys[$urandom_range(0, shadow_count - 1)];
    else
      k = random_key();
    send_command(cmd, k, $urandom());
  endtask

  task automatic empty_table();
    while (shadow_count > 0) send_command(OP_REMOVE, shadow_keys[shadow_count-1], '0);
  endtask

  // Commands against an empty table
  task automatic test_empty_table();
    send_command(OP_REMOVE, 0, '0);
    send_command(OP_MODIFY, KEY_MIN, '1);
    send_command(CMD_UNUSED, '1, '1);
  endtask

  // Extreme keys and values, duplicates, misses above the live keys
  task automatic test_ordering_and_duplicates();
    send_command(OP_ADD, KEY_MAX, '1);
    send_command(OP_ADD, KEY_MIN, '0);
    send_command(OP_ADD, 0, 32'h5555_5555);
    send_command(OP_ADD, -1, 32'hAAAA_AAAA);
    repeat (3) send_command(OP_ADD, 5, $urandom());
    send_command(OP_MODIFY, 5, '1);
    send_command(OP_REMOVE, 5, '0);
    send_command(OP_REMOVE, KEY_MIN, '1);
    send_command(OP_REMOVE, KEY_MAX, '0);
    send_command(OP_MODIFY, -1, '0);
    send_command(OP_REMOVE, 7, '0);
    send_command(OP_MODIFY, KEY_MAX, '1);
    send_command(CMD_UNUSED, '0, '0);
  endtask

  // Capacity below count, one, zero, above depth, and the reset value
  task automatic test_capacity_limits();
    write_capacity(1);
    send_command(OP_ADD, 3, $urandom());
    send_command(OP_MODIFY, 5, $urandom());
    send_command(OP_REMOVE, -1, '0);
    send_command(OP_ADD, 3, $urandom());
    empty_table();
    send_command(OP_ADD, 9, $urandom());
    send_command(OP_ADD, 9, $urandom());
    write_capacity(0);
    send_command(OP_ADD, -9, $urandom());
    send_command(OP_REMOVE, 9, '0);
    send_command(OP_ADD, -9, $urandom());
    write_capacity(127);
    while (shadow_count < TABLE_DEPTH) send_command(OP_ADD, random_key(), $urandom());
    send_command(OP_ADD, KEY_MAX, $urandom());
    write_capacity(64);
    send_command(OP_ADD, KEY_MIN, $urandom());
    send_command(OP_REMOVE, shadow_keys[TABLE_DEPTH/2], '0);
    send_command(OP_ADD, KEY_MIN, $urandom());
  endtask

  // Random phases over a sweep of capacities and traffic mixes
  task automatic test_random_traffic();
    int caps[12] = '{64, 3, 127, 17, 0, 40, 1, 64, 100, 8, 63, 65};
    for (int p = 0; p < 12; p++) begin
      write_capacity(caps[p]);
      idling_on = (p % 4 != 3);
      repeat (110) send_random_command(p % 3);
    end
    idling_on = 1'b1;
  endtask

  // Long receiver hold to back the table up, then a full pause of the sender
  task automatic test_backpressure();
    write_capacity(32);
    long_hold_cycles = LONG_HOLD;
    repeat (30) send_random_command(1);
    wait_for_drain();
    repeat (20) send_random_command(1);
  endtask

  // Receiver: random stall per transaction, plus any long hold requested
  initial begin : reply_sink
    int hold;
    forever begin
      @(negedge clk);
      hold = idling_on ? $urandom_range(0, 5) : 0;
      if (long_hold_cycles > 0) begin
        hold += long_hold_cycles;
        long_hold_cycles = 0;
        long_holds++;
      end
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted reply with the oldest expectation
  always @(posedge clk) begin : check_replies
    table_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        note_mismatch($sformatf("reply with nothing pending: status %0d, count %0d",
                                out_status, out_entry_count));
      end else begin
        want = expected_replies.pop_front();
        replies_checked++;
        if (out_status !== want.status)
          note_mismatch($sformatf("status: expected %0d, got %0d", want.status, out_status));
        if (out_entry_count !== want.entry_count)
          note_mismatch($sformatf("entry_count: expected %0d, got %0d",
                                  want.entry_count, out_entry_count));
      end
    end
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_empty_table();
    test_ordering_and_duplicates();
    test_capacity_limits();
    test_random_traffic();
    test_backpressure();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d commands, %0d replies checked, %0d capacity writes.",
             commands_sent, replies_checked, capacity_writes);
    $display("Table peaked at %0d entries; %0d long output holds; %0d errors.",
             peak_count, long_holds, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sorted_key_value_table_top.f =====
sv/skvt_pkg.sv
sv/skvt_ram.sv
sv/skvt_dp.sv
sv/skvt_ctrl.sv
sv/sorted_key_value_table_top.sv
bench/tb_top.sv
